FILE: sv/tkps_pkg.sv
// Shared types and codes for the top-k pair sums block.
package tkps_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_PAIR_COUNT   = 1'b0;
    localparam logic CFG_RESULT_COUNT = 1'b1;

    localparam int VAL_W = 16;
    localparam int SUM_W = 17;
    localparam int CFG_W = 7;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [VAL_W-1:0] item_value;
    } in_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] pair_sum;
        logic                    last_sum;
    } out_word_t;

    // Operation applied to every cell of a sort chain at once.
    typedef enum logic [1:0] {
        SORT_HOLD,
        SORT_LOAD,
        SORT_DRAIN,
        SORT_STEP
    } sort_op_t;

    // Operation applied to every cell of the candidate queue at once.
    typedef enum logic [1:0] {
        Q_HOLD,
        Q_CLEAR,
        Q_POP,
        Q_PUSH
    } queue_op_t;

endpackage

FILE: sv/top_k_pair_sums.sv
// Top level of the top-k pair sums block: list stores, sort chains, candidate queue.
//
// Load words (req_type 0 or 1) write one value into the first or second list
// store each; loads beyond the effective list length n (pair_count,
// saturated to MAX_LIST_LEN) are dropped. A compute word (req_type 2) sorts
// both lists and emits the k largest sums a[i]+b[j] in non-increasing order,
// where k is result_count clamped to n*n and MAX_RESULTS, marking the final
// one with last_sum. A compute runs a setup step, streams both stores into
// two chains of sort cells, runs n odd-even transposition rounds, writes the
// sorted lists back and seeds the queue, then for each result does one pop
// plus a read and an insert for each of at most two new candidates, as each
// list RAM has a single read port. Candidates live in a chain of
// MAX_RESULTS+1 queue cells that stays sorted through each pop and insert.
// No input word is taken while a compute runs; loads are taken again once
// the last sum sits in the output register. The output register holds one
// word while the downstream side stalls. Configuration is written on cfg_we
// and takes effect at the next compute or load.
module top_k_pair_sums
    import tkps_pkg::*;
#(
    parameter int MAX_LIST_LEN = 64,
    parameter int MAX_RESULTS  = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int LW = $clog2(MAX_LIST_LEN);
    localparam int NW = $clog2(MAX_LIST_LEN + 1);
    localparam int KW = $clog2(MAX_RESULTS + 1);
    localparam int QD = MAX_RESULTS + 1;
    localparam int IW = 2 * LW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FILL,
        ST_SORT,
        ST_WB,
        ST_READ,
        ST_INSERT,
        ST_POP
    } state_t;

    state_t           state_reg,  state_next;
    logic [CFG_W-1:0] pair_count_reg, pair_count_next;
    logic [CFG_W-1:0] result_count_reg, result_count_next;
    logic [NW-1:0]    fill_a_reg, fill_a_next;
    logic [NW-1:0]    fill_b_reg, fill_b_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic [KW-1:0]    emit_reg, emit_next;
    logic [LW-1:0]    cur_i_reg, cur_i_next;
    logic [LW-1:0]    cur_j_reg, cur_j_next;
    logic [LW-1:0]    ins_i_reg, ins_i_next;
    logic [LW-1:0]    ins_j_reg, ins_j_next;
    logic             sec_reg, sec_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_data_reg, out_data_next;

    logic [NW-1:0]     n_eff;
    logic [2*NW-1:0]   nn;
    logic [31:0]       k_min;
    logic [KW-1:0]     k_calc;
    logic [LW-1:0]     n_last;

    logic              we_a, we_b;
    logic [LW-1:0]     waddr_a, waddr_b;
    logic [VAL_W-1:0]  wdata_a, wdata_b;
    logic [LW-1:0]     raddr_a, raddr_b;
    logic [VAL_W-1:0]  rdata_a, rdata_b;

    sort_op_t          sort_op;
    queue_op_t         q_op;
    logic signed [SUM_W-1:0] new_sum;
    logic [IW-1:0]     new_idx;

    logic signed [VAL_W-1:0] val_a [MAX_LIST_LEN];
    logic signed [VAL_W-1:0] val_b [MAX_LIST_LEN];

    logic                    q_valid [QD];
    logic signed [SUM_W-1:0] q_sum   [QD];
    logic [IW-1:0]           q_idx   [QD];
    logic                    q_keep  [QD];

    logic              in_fire;
    logic              out_free;
    logic [LW-1:0]     top_i;
    logic [LW-1:0]     top_j;

    // Effective list length: pair_count saturated to the store depth.
    always_comb
    begin
        if (int'(pair_count_reg) > MAX_LIST_LEN)
        begin
            n_eff = NW'(MAX_LIST_LEN);
        end
        else
        begin
            n_eff = NW'(pair_count_reg);
        end
    end

    // Result count clamp against n*n and the queue size.
    always_comb
    begin
        nn = (2 * NW)'(n_reg) * (2 * NW)'(n_reg);
        if (32'(result_count_reg) < 32'(nn))
        begin
            k_min = 32'(result_count_reg);
        end
        else
        begin
            k_min = 32'(nn);
        end
        if (k_min > 32'(MAX_RESULTS))
        begin
            k_calc = KW'(MAX_RESULTS);
        end
        else
        begin
            k_calc = KW'(k_min);
        end
    end

    assign n_last   = LW'(n_reg - NW'(1));
    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign top_i    = q_idx[0][IW-1:LW];
    assign top_j    = q_idx[0][LW-1:0];

    assign new_sum = SUM_W'($signed(rdata_a)) + SUM_W'($signed(rdata_b));
    assign new_idx = {ins_i_reg, ins_j_reg};

    always_comb
    begin
        state_next        = state_reg;
        pair_count_next   = pair_count_reg;
        result_count_next = result_count_reg;
        fill_a_next       = fill_a_reg;
        fill_b_next       = fill_b_reg;
        n_next            = n_reg;
        k_next            = k_reg;
        cnt_next          = cnt_reg;
        pend_next         = pend_reg;
        emit_next         = emit_reg;
        cur_i_next        = cur_i_reg;
        cur_j_next        = cur_j_reg;
        ins_i_next        = ins_i_reg;
        ins_j_next        = ins_j_reg;
        sec_next          = sec_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_data_next     = out_data_reg;

        we_a    = 1'b0;
        we_b    = 1'b0;
        waddr_a = fill_a_reg[LW-1:0];
        waddr_b = fill_b_reg[LW-1:0];
        wdata_a = in_data.item_value;
        wdata_b = in_data.item_value;
        raddr_a = ins_i_reg;
        raddr_b = ins_j_reg;
        sort_op = SORT_HOLD;
        q_op    = Q_HOLD;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAIR_COUNT:   pair_count_next   = cfg_data;
                CFG_RESULT_COUNT: result_count_next = cfg_data;
                default:          pair_count_next   = pair_count_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (in_data.req_type == REQ_LOAD_A)
                    begin
                        if (fill_a_reg < n_eff)
                        begin
                            we_a        = 1'b1;
                            fill_a_next = fill_a_reg + NW'(1);
                        end
                    end
                    else if (in_data.req_type == REQ_LOAD_B)
                    begin
                        if (fill_b_reg < n_eff)
                        begin
                            we_b        = 1'b1;
                            fill_b_next = fill_b_reg + NW'(1);
                        end
                    end
                    else if (in_data.req_type == REQ_COMPUTE)
                    begin
                        fill_a_next = '0;
                        fill_b_next = '0;
                        n_next      = n_eff;
                        state_next  = ST_SETUP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SETUP:
            begin
                q_op      = Q_CLEAR;
                k_next    = k_calc;
                cnt_next  = '0;
                pend_next = 1'b0;
                emit_next = '0;
                if (n_reg == '0 || k_calc == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                // Reads are issued back to back; each returning word shifts in.
                raddr_a = cnt_reg[LW-1:0];
                raddr_b = cnt_reg[LW-1:0];
                if (pend_reg)
                begin
                    sort_op = SORT_LOAD;
                end
                pend_next = (cnt_reg < n_reg);
                if (cnt_reg < n_reg)
                begin
                    cnt_next = cnt_reg + NW'(1);
                end
                else if (!pend_reg)
                begin
                    cnt_next   = '0;
                    sort_op    = SORT_HOLD;
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                sort_op  = SORT_STEP;
                cnt_next = cnt_reg + NW'(1);
                if (cnt_reg == n_reg - NW'(1))
                begin
                    cnt_next   = '0;
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                sort_op  = SORT_DRAIN;
                we_a     = 1'b1;
                we_b     = 1'b1;
                waddr_a  = cnt_reg[LW-1:0];
                waddr_b  = cnt_reg[LW-1:0];
                wdata_a  = val_a[0];
                wdata_b  = val_b[0];
                cnt_next = cnt_reg + NW'(1);
                if (cnt_reg == n_reg - NW'(1))
                begin
                    ins_i_next = n_last;
                    ins_j_next = n_last;
                    sec_next   = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                q_op = Q_PUSH;
                if (sec_reg)
                begin
                    ins_i_next = cur_i_reg - LW'(1);
                    ins_j_next = cur_j_reg;
                    sec_next   = 1'b0;
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    q_op                   = Q_POP;
                    out_valid_next         = 1'b1;
                    out_data_next.pair_sum = q_sum[0];
                    out_data_next.last_sum = (KW'(emit_reg + KW'(1)) == k_reg);
                    emit_next              = emit_reg + KW'(1);
                    cur_i_next             = top_i;
                    cur_j_next             = top_j;
                    // Each pair is generated once: (i,j-1) whenever j>0, (i-1,j)
                    // only from the last column.
                    if (KW'(emit_reg + KW'(1)) == k_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (top_j != '0)
                    begin
                        ins_i_next = top_i;
                        ins_j_next = top_j - LW'(1);
                        sec_next   = (top_j == n_last) && (top_i != '0);
                        state_next = ST_READ;
                    end
                    else if ((top_j == n_last) && (top_i != '0))
                    begin
                        ins_i_next = top_i - LW'(1);
                        ins_j_next = top_j;
                        sec_next   = 1'b0;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pair_count_reg   <= CFG_W'(1);
            result_count_reg <= CFG_W'(1);
            fill_a_reg       <= '0;
            fill_b_reg       <= '0;
            n_reg            <= '0;
            k_reg            <= '0;
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            emit_reg         <= '0;
            sec_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pair_count_reg   <= pair_count_next;
            result_count_reg <= result_count_next;
            fill_a_reg       <= fill_a_next;
            fill_b_reg       <= fill_b_next;
            n_reg            <= n_next;
            k_reg            <= k_next;
            cnt_reg          <= cnt_next;
            pend_reg         <= pend_next;
            emit_reg         <= emit_next;
            sec_reg          <= sec_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_i_reg    <= cur_i_next;
        cur_j_reg    <= cur_j_next;
        ins_i_reg    <= ins_i_next;
        ins_j_reg    <= ins_j_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tkps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_LIST_LEN)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr_a),
        .wdata (wdata_a),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    tkps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_LIST_LEN)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr_b),
        .wdata (wdata_b),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    // Sort chains: cell 0 takes the word read from the store, and the lowest
    // n cells take part in the transposition rounds.
    for (genvar k = 0; k < MAX_LIST_LEN; k++)
    begin : g_sort
        logic                    pair_lo;
        logic                    pair_hi;
        logic signed [VAL_W-1:0] prev_a, prev_b, next_a, next_b;

        assign pair_lo = ((k % 2) == int'(cnt_reg[0])) && ((k + 1) < int'(n_reg));
        assign pair_hi = (k >= 1) && (((k + 1) % 2) == int'(cnt_reg[0]))
                         && (k < int'(n_reg));

        if (k == 0)
        begin : g_first
            assign prev_a = $signed(rdata_a);
            assign prev_b = $signed(rdata_b);
        end
        else
        begin : g_mid
            assign prev_a = val_a[k-1];
            assign prev_b = val_b[k-1];
        end

        if (k == MAX_LIST_LEN - 1)
        begin : g_end
            assign next_a = '0;
            assign next_b = '0;
        end
        else
        begin : g_inner
            assign next_a = val_a[k+1];
            assign next_b = val_b[k+1];
        end

        tkps_sort_cell u_cell_a (
            .clk      (clk),
            .op       (sort_op),
            .prev_val (prev_a),
            .next_val (next_a),
            .pair_lo  (pair_lo),
            .pair_hi  (pair_hi),
            .val      (val_a[k])
        );

        tkps_sort_cell u_cell_b (
            .clk      (clk),
            .op       (sort_op),
            .prev_val (prev_b),
            .next_val (next_b),
            .pair_lo  (pair_lo),
            .pair_hi  (pair_hi),
            .val      (val_b[k])
        );
    end

    // Candidate queue: cell 0 always holds the largest pending sum.
    for (genvar k = 0; k < QD; k++)
    begin : g_queue
        logic                    prev_keep;
        logic                    prev_valid;
        logic signed [SUM_W-1:0] prev_sum;
        logic [IW-1:0]           prev_idx;
        logic                    next_valid;
        logic signed [SUM_W-1:0] next_sum;
        logic [IW-1:0]           next_idx;

        if (k == 0)
        begin : g_head
            assign prev_keep  = 1'b1;
            assign prev_valid = 1'b0;
            assign prev_sum   = '0;
            assign prev_idx   = '0;
        end
        else
        begin : g_body
            assign prev_keep  = q_keep[k-1];
            assign prev_valid = q_valid[k-1];
            assign prev_sum   = q_sum[k-1];
            assign prev_idx   = q_idx[k-1];
        end

        if (k == QD - 1)
        begin : g_tail
            assign next_valid = 1'b0;
            assign next_sum   = '0;
            assign next_idx   = '0;
        end
        else
        begin : g_link
            assign next_valid = q_valid[k+1];
            assign next_sum   = q_sum[k+1];
            assign next_idx   = q_idx[k+1];
        end

        tkps_queue_cell #(
            .IDX_W (IW)
        ) u_qcell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (q_op),
            .new_sum    (new_sum),
            .new_idx    (new_idx),
            .prev_keep  (prev_keep),
            .prev_valid (prev_valid),
            .prev_sum   (prev_sum),
            .prev_idx   (prev_idx),
            .next_valid (next_valid),
            .next_sum   (next_sum),
            .next_idx   (next_idx),
            .valid      (q_valid[k]),
            .sum        (q_sum[k]),
            .idx        (q_idx[k]),
            .keep       (q_keep[k])
        );
    end

endmodule

FILE: sv/tkps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tkps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/tkps_sort_cell.sv
// One cell of an odd-even transposition sort chain.
module tkps_sort_cell
    import tkps_pkg::*;
(
    input  logic                    clk,
    input  sort_op_t                op,
    input  logic signed [VAL_W-1:0] prev_val,
    input  logic signed [VAL_W-1:0] next_val,
    input  logic                    pair_lo,
    input  logic                    pair_hi,
    output logic signed [VAL_W-1:0] val
);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;

    // The lower cell of a pair keeps the minimum, the upper one the maximum.
    always_comb
    begin
        val_next = val_reg;
        unique case (op)
            SORT_HOLD:  val_next = val_reg;
            SORT_LOAD:  val_next = prev_val;
            SORT_DRAIN: val_next = next_val;
            SORT_STEP:
            begin
                if (pair_lo)
                begin
                    val_next = (next_val < val_reg) ? next_val : val_reg;
                end
                else if (pair_hi)
                begin
                    val_next = (prev_val > val_reg) ? prev_val : val_reg;
                end
            end
            default:    val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

FILE: sv/tkps_queue_cell.sv
// One cell of the systolic candidate queue, kept sorted by sum, largest first.
module tkps_queue_cell
    import tkps_pkg::*;
#(
    parameter int IDX_W = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  queue_op_t               op,
    input  logic signed [SUM_W-1:0] new_sum,
    input  logic [IDX_W-1:0]        new_idx,
    input  logic                    prev_keep,
    input  logic                    prev_valid,
    input  logic signed [SUM_W-1:0] prev_sum,
    input  logic [IDX_W-1:0]        prev_idx,
    input  logic                    next_valid,
    input  logic signed [SUM_W-1:0] next_sum,
    input  logic [IDX_W-1:0]        next_idx,
    output logic                    valid,
    output logic signed [SUM_W-1:0] sum,
    output logic [IDX_W-1:0]        idx,
    output logic                    keep
);

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;

    // A cell keeps its entry on a push when that entry ranks at or above the new one.
    assign keep = valid_reg && (sum_reg >= new_sum);

    always_comb
    begin
        valid_next = valid_reg;
        sum_next   = sum_reg;
        idx_next   = idx_reg;
        unique case (op)
            Q_HOLD:  valid_next = valid_reg;
            Q_CLEAR: valid_next = 1'b0;
            Q_POP:
            begin
                valid_next = next_valid;
                sum_next   = next_sum;
                idx_next   = next_idx;
            end
            Q_PUSH:
            begin
                if (!keep)
                begin
                    if (prev_keep)
                    begin
                        valid_next = 1'b1;
                        sum_next   = new_sum;
                        idx_next   = new_idx;
                    end
                    else
                    begin
                        valid_next = prev_valid;
                        sum_next   = prev_sum;
                        idx_next   = prev_idx;
                    end
                end
            end
            default: valid_next = valid_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        idx_reg <= idx_next;
    end

    assign valid = valid_reg;
    assign sum   = sum_reg;
    assign idx   = idx_reg;

endmodule
